// File: rtl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

    // request kinds
    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_SET   = 2'd1,
        K_REL   = 2'd2,
        K_CHECK = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam int SLOT_W = 11;
    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] BYTES_RESET = 9'd256;

    // controller to datapath
    typedef struct packed {
        logic clear;    // write zero at clear counter
        logic load;     // take request word, read first byte
        logic advance;  // scan on to next byte
        logic finish;   // write back and load result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_more;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/bsa_req_if.sv
`timescale 1ns / 1ps

interface bsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [10:0] slot_index;

    modport source (output valid, output kind, output slot_index, input ready);
    modport sink (input valid, input kind, input slot_index, output ready);
endinterface

// File: rtl/bsa_rsp_if.sv
`timescale 1ns / 1ps

interface bsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] slot;
    logic        bit_value;
    logic [1:0]  status;

    modport source (output valid, output slot, output bit_value, output status, input ready);
    modport sink (input valid, input slot, input bit_value, input status, output ready);
endinterface

// File: rtl/bitmap_slot_allocator.sv
`timescale 1ns / 1ps

// channel   dir  handshake      word
// i_req     in   valid/ready    kind, slot_index
// o_rsp     out  valid/ready    slot, bit_value, status
// i_cfg_*   in   write enable   bytes_in_use (9 bits)
//
// set, release and check pass through the accepting cycle, then an evaluate
//   state whose closing edge loads the result register
// allocate scans on from the hint past full bytes; the single read port of
//   the bitmap memory gives one byte per cycle
// after reset a clearing pass zeroes every byte of the bitmap, no word is
//   taken until it ends
// a finished result sits in the output register; the next word is taken
//   while it waits, the block only stalls to load a second result

module bitmap_slot_allocator #(
    parameter int TABLE_BYTES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bsa_pkg::CFG_W-1:0] i_cfg_wdata,
    bsa_req_if.sink                   i_req,
    bsa_rsp_if.source                 o_rsp
);

    // controller/datapath handshake
    bsa_pkg::t_cmd  w_cmd;
    bsa_pkg::t_stat w_stat;
    logic           w_ready;

    assign i_req.ready = w_ready;

    // sequencer: clear pass, idle, evaluate/scan
    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (w_stat),
        .o_req_ready (w_ready),
        .o_cmd       (w_cmd)
    );

    // bitmap memory, hint, scan pointer and result register
    bsa_dp #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_kind       (i_req.kind),
        .i_slot_index (i_req.slot_index),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_rsp        (o_rsp)
    );

endmodule

// File: rtl/bsa_ctrl.sv
`timescale 1ns / 1ps

module bsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  bsa_pkg::t_stat i_stat,
    output logic           o_req_ready,
    output bsa_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.scan_more) begin
                    o_cmd.advance = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/bsa_dp.sv
`timescale 1ns / 1ps

module bsa_dp #(
    parameter int TABLE_BYTES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bsa_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic [1:0]                 i_kind,
    input  logic [bsa_pkg::SLOT_W-1:0] i_slot_index,
    input  bsa_pkg::t_cmd              i_cmd,
    output bsa_pkg::t_stat             o_stat,
    bsa_rsp_if.source                  o_rsp
);

    localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
    localparam int CW = $clog2(TABLE_BYTES + 1);
    localparam int LW = (CW > bsa_pkg::CFG_W) ? CW : bsa_pkg::CFG_W;
    localparam logic [LW-1:0] TABLE_LIM = LW'(TABLE_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_BYTES - 1);

    logic [7:0] mem [TABLE_BYTES];

    logic [bsa_pkg::CFG_W-1:0]  r_bytes_in_use;
    logic [AW-1:0]              r_hint;
    logic [AW-1:0]              r_clr_cnt;
    bsa_pkg::t_kind             r_kind;
    logic [bsa_pkg::SLOT_W-1:0] r_idx;
    logic [LW-1:0]              r_ptr;
    logic [7:0]                 r_rdata;
    logic                       r_out_valid;
    logic [bsa_pkg::SLOT_W-1:0] r_out_slot;
    logic                       r_out_bit;
    bsa_pkg::t_status           r_out_status;

    logic [LW-1:0]              live_n;
    logic [LW-1:0]              cfg_ext;
    logic [LW-1:0]              ptr_load;
    logic [LW-1:0]              ptr_inc;
    logic [AW-1:0]              rd_addr;
    logic                       rd_en;
    logic                       in_range;
    logic [2:0]                 free_bit;
    logic [7:0]                 bit_mask;
    logic [7:0]                 wr_byte;
    logic                       wr_req;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [7:0]                 wr_data;
    logic [AW-1:0]              ptr_byte;
    logic [bsa_pkg::SLOT_W-1:0] res_slot;
    logic                       res_bit;
    bsa_pkg::t_status           res_status;
    logic [LW+2:0]              alloc_slot;

    function automatic logic t_kind_is_alloc(input logic [1:0] k);
        return bsa_pkg::t_kind'(k) == bsa_pkg::K_ALLOC;
    endfunction

    // bytes actually live: min(bytes_in_use, table size)
    assign cfg_ext  = LW'(r_bytes_in_use);
    assign live_n   = (cfg_ext > TABLE_LIM) ? TABLE_LIM : cfg_ext;
    assign ptr_load = (t_kind_is_alloc(i_kind)) ? LW'(r_hint)
                                                : LW'(i_slot_index[bsa_pkg::SLOT_W-1:3]);
    assign ptr_inc  = r_ptr + LW'(1);
    assign rd_en    = i_cmd.load | i_cmd.advance;
    assign rd_addr  = i_cmd.load ? AW'(ptr_load) : AW'(ptr_inc);
    assign in_range = r_ptr < live_n;
    assign ptr_byte = AW'(r_ptr);
    assign bit_mask = 8'(1) << r_idx[2:0];

    // lowest clear bit of the byte under the scan
    always_comb begin
        free_bit = 3'd7;
        for (int k = 6; k >= 0; k--) begin
            if (!r_rdata[k]) begin
                free_bit = 3'(k);
            end
        end
    end

    assign alloc_slot = {r_ptr, free_bit};

    always_comb begin
        res_slot   = r_idx;
        res_bit    = 1'b0;
        res_status = bsa_pkg::ST_OK;
        wr_req     = 1'b0;
        wr_byte    = r_rdata;
        case (r_kind)
            bsa_pkg::K_ALLOC: begin
                if (!in_range) begin
                    res_slot   = '0;
                    res_status = bsa_pkg::ST_FULL;
                end else begin
                    res_slot = alloc_slot[bsa_pkg::SLOT_W-1:0];
                    wr_req   = 1'b1;
                    wr_byte  = r_rdata | (8'(1) << free_bit);
                end
            end
            bsa_pkg::K_SET: begin
                wr_req  = in_range;
                wr_byte = r_rdata | bit_mask;
            end
            bsa_pkg::K_REL: begin
                wr_req  = in_range;
                wr_byte = r_rdata & ~bit_mask;
            end
            bsa_pkg::K_CHECK: begin
                res_bit = in_range & r_rdata[r_idx[2:0]];
            end
            default: begin
                res_slot = r_idx;
            end
        endcase
        if (!in_range && r_kind != bsa_pkg::K_ALLOC) begin
            res_status = bsa_pkg::ST_RANGE;
        end
    end

    assign o_stat.scan_more = (r_kind == bsa_pkg::K_ALLOC) && in_range
                              && (r_rdata == bsa_pkg::BYTE_FULL);
    assign o_stat.clr_last  = r_clr_cnt == CLR_LAST;
    assign o_stat.out_free  = !r_out_valid || o_rsp.ready;

    assign wr_en   = i_cmd.clear | (i_cmd.finish & wr_req);
    assign wr_addr = i_cmd.clear ? r_clr_cnt : ptr_byte;
    assign wr_data = i_cmd.clear ? 8'h00 : wr_byte;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_use <= bsa_pkg::BYTES_RESET;
            r_hint         <= '0;
            r_clr_cnt      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bytes_in_use <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.finish && in_range) begin
                if (r_kind == bsa_pkg::K_ALLOC) begin
                    r_hint <= ptr_byte;
                end else if (r_kind == bsa_pkg::K_REL && r_hint > ptr_byte) begin
                    r_hint <= ptr_byte;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= bsa_pkg::t_kind'(i_kind);
            r_idx  <= i_slot_index;
            r_ptr  <= ptr_load;
        end else if (i_cmd.advance) begin
            r_ptr <= ptr_inc;
        end
        if (i_cmd.finish) begin
            r_out_slot   <= res_slot;
            r_out_bit    <= res_bit;
            r_out_status <= res_status;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.slot      = r_out_slot;
    assign o_rsp.bit_value = r_out_bit;
    assign o_rsp.status    = r_out_status;

endmodule
